### rtl/postfix_expression_evaluator_core_assert.svh
// Assertion macros for the postfix evaluator. Define NO_ASSERTIONS to drop them.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, masked while reset is asserted
`define PEE_CHECK(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("postfix evaluator check failed");
// Clocked check that also holds during reset
`define PEE_CHECK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("postfix evaluator check failed");
`else
`define PEE_CHECK(lbl, prop)
`define PEE_CHECK_ALWAYS(lbl, prop)
`endif
`endif

### rtl/pee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types, constants and fixed-point helpers of the postfix evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_W       = 32 + FRAC_BITS;
    localparam int DCNT_W      = $clog2(DIV_W);
    localparam int POW_CAP     = 63;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic [31:0] INT_MAX_V = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN_V = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW, OP_DROP, OP_END
    } op_kind_t;

    // One classified command between front and back
    typedef struct packed {
        op_kind_t   kind;
        logic [3:0] digit;
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE, S_POPE, S_POPB, S_LATB, S_CALC, S_MULP, S_MULF,
        S_DIV, S_DIVF, S_PUSH, S_ENDR, S_OUT
    } exec_state_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } fm_t;

    // Magnitude of a signed 32-bit word
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Rebuild a signed word from sign and magnitude, saturating
    function automatic fm_t from_mag(input logic neg, input logic [63:0] mag);
        fm_t r;
        r.sat   = 1'b0;
        r.value = mag[31:0];
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.sat   = 1'b1;
                r.value = INT_MIN_V;
            end else begin
                r.value = ~mag[31:0] + 32'd1;
            end
        end else if (mag > 64'h0000_0000_7FFF_FFFF) begin
            r.sat   = 1'b1;
            r.value = INT_MAX_V;
        end
        return r;
    endfunction

endpackage

### rtl/pee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_front
// Accept characters, classify them and queue commands for the back end.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_core_assert.svh"
module pee_front
    import pee_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_end_marker,
    output logic       op_valid,
    input  logic       op_ready,
    output op_t        op_out
);

    op_t        fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    op_t        op_in;
    logic       keep;
    logic       push_en, pop_en;

    // Classify the incoming transaction; spaces are dropped here
    always_comb begin
        op_in.kind  = OP_DROP;
        op_in.digit = s_character[3:0];
        keep        = 1'b1;
        if (s_end_marker) begin
            op_in.kind = OP_END;
        end else if (s_character >= CH_ZERO && s_character <= CH_NINE) begin
            op_in.kind = OP_PUSH;
        end else begin
            unique case (s_character)
                CH_SPACE: keep       = 1'b0;
                CH_PLUS:  op_in.kind = OP_ADD;
                CH_MINUS: op_in.kind = OP_SUB;
                CH_STAR:  op_in.kind = OP_MUL;
                CH_SLASH: op_in.kind = OP_DIV;
                CH_CARET: op_in.kind = OP_POW;
                default:  op_in.kind = OP_DROP;
            endcase
        end
    end

    assign s_ready  = (cnt_reg != 2'd2);
    assign op_valid = (cnt_reg != 2'd0);
    assign op_out   = fifo_reg[rd_ptr_reg];
    assign push_en  = s_valid && s_ready && keep;
    assign pop_en   = op_valid && op_ready;

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push_en;
        rd_ptr_next = rd_ptr_reg ^ pop_en;
        cnt_next    = cnt_reg + {1'b0, push_en} - {1'b0, pop_en};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queue payload
    always_ff @(posedge aclk) begin
        if (push_en) begin
            fifo_reg[wr_ptr_reg] <= op_in;
        end
    end

    `PEE_CHECK(a_fifo_bound, cnt_reg != 2'd3)
    `PEE_CHECK(a_push_lands, push_en |=> cnt_reg != 2'd0)
    `PEE_CHECK(a_pop_has_data, pop_en |-> cnt_reg != 2'd0)

endmodule

### rtl/pee_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_exec
// Operand stack and sequencer: pops, fixed-point arithmetic, pushes, results.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_core_assert.svh"
module pee_exec
    import pee_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        op_valid,
    output logic        op_ready,
    input  op_t         op_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic [2:0]  m_status
);

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] rd_data_reg;

    exec_state_t        state_reg, state_next;
    op_t                op_reg, op_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    status_t            sticky_reg, sticky_next;
    logic [31:0]        e_reg, e_next;
    logic [31:0]        b_reg, b_next;
    logic [31:0]        res_reg, res_next;
    logic [31:0]        ma_reg, ma_next;
    logic [31:0]        mb_reg, mb_next;
    logic               neg_reg, neg_next;
    logic [63:0]        prod_reg, prod_next;
    logic [5:0]         mcnt_reg, mcnt_next;
    logic [31:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [31:0]        den_reg, den_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic               fmem_reg, fmem_next;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_value_reg, m_value_next;
    status_t            m_status_reg, m_status_next;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic               flag_en;
    status_t            flag_code;
    logic               out_free;
    logic signed [32:0] sum;
    logic [31:0]        em1;
    logic [31:0]        pow_n;
    logic [32:0]        trial;
    fm_t                fm;

    assign out_free = !m_valid_reg || m_ready;
    assign op_ready = (state_reg == S_IDLE);
    assign em1      = e_reg - 32'd1;
    assign pow_n    = em1 >> FRAC_BITS;
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};

    // Sequencer: next state, datapath updates and stack accesses
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        count_next    = count_reg;
        e_next        = e_reg;
        b_next        = b_reg;
        res_next      = res_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        mcnt_next     = mcnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        den_next      = den_reg;
        dcnt_next     = dcnt_reg;
        fmem_next     = fmem_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        rd_en         = 1'b0;
        rd_addr       = ADDR_W'(count_reg - CNT_W'(1));
        wr_en         = 1'b0;
        flag_en       = 1'b0;
        flag_code     = ST_OK;
        sum           = '0;
        fm            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (op_valid) begin
                    op_next = op_in;
                    unique case (op_in.kind)
                        OP_PUSH: begin
                            res_next   = 32'({28'd0, op_in.digit} << FRAC_BITS);
                            state_next = S_PUSH;
                        end
                        OP_END:  state_next = S_ENDR;
                        default: state_next = S_POPE;
                    endcase
                end
            end
            // Pop the top operand
            S_POPE: begin
                fmem_next = (count_reg != '0);
                if (count_reg == '0) begin
                    flag_en   = 1'b1;
                    flag_code = ST_UNDER;
                end else begin
                    rd_en      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = S_POPB;
            end
            // Capture the top operand, pop the one below
            S_POPB: begin
                e_next    = fmem_reg ? rd_data_reg : 32'd0;
                fmem_next = (count_reg != '0);
                if (count_reg == '0) begin
                    flag_en   = 1'b1;
                    flag_code = ST_UNDER;
                end else begin
                    rd_en      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = S_LATB;
            end
            S_LATB: begin
                b_next     = fmem_reg ? rd_data_reg : 32'd0;
                state_next = S_CALC;
            end
            // Dispatch the operator
            S_CALC: begin
                unique case (op_reg.kind)
                    OP_ADD, OP_SUB: begin
                        if (op_reg.kind == OP_ADD) begin
                            sum = {b_reg[31], b_reg} + {e_reg[31], e_reg};
                        end else begin
                            sum = {b_reg[31], b_reg} - {e_reg[31], e_reg};
                        end
                        res_next = sum[31:0];
                        if (sum[32] != sum[31]) begin
                            flag_en   = 1'b1;
                            flag_code = ST_SAT;
                            res_next  = sum[32] ? INT_MIN_V : INT_MAX_V;
                        end
                        state_next = S_PUSH;
                    end
                    OP_MUL: begin
                        ma_next    = b_reg;
                        mb_next    = e_reg;
                        mcnt_next  = 6'd1;
                        state_next = S_MULP;
                    end
                    OP_POW: begin
                        if (e_reg == 32'd0) begin
                            res_next   = FX_ONE;
                            state_next = S_PUSH;
                        end else if ($signed(e_reg) <= FX_ONE) begin
                            res_next   = b_reg;
                            state_next = S_PUSH;
                        end else begin
                            ma_next    = b_reg;
                            mb_next    = b_reg;
                            mcnt_next  = (pow_n > 32'(POW_CAP)) ? 6'(POW_CAP) : pow_n[5:0];
                            state_next = S_MULP;
                        end
                    end
                    OP_DIV: begin
                        if (e_reg == 32'd0) begin
                            flag_en    = 1'b1;
                            flag_code  = ST_DIVZ;
                            res_next   = 32'd0;
                            state_next = S_PUSH;
                        end else begin
                            rem_next   = 32'd0;
                            quo_next   = DIV_W'({mag32(b_reg), {FRAC_BITS{1'b0}}});
                            den_next   = mag32(e_reg);
                            neg_next   = b_reg[31] ^ e_reg[31];
                            dcnt_next  = DCNT_W'(DIV_W - 1);
                            state_next = S_DIV;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            // Multiply magnitudes
            S_MULP: begin
                prod_next  = 64'(mag32(ma_reg)) * 64'(mag32(mb_reg));
                neg_next   = ma_reg[31] ^ mb_reg[31];
                state_next = S_MULF;
            end
            // Scale, saturate and loop for power
            S_MULF: begin
                fm        = from_mag(neg_reg, prod_reg >> FRAC_BITS);
                flag_en   = fm.sat;
                flag_code = ST_SAT;
                ma_next   = fm.value;
                res_next  = fm.value;
                mcnt_next = mcnt_reg - 6'd1;
                state_next = (mcnt_reg == 6'd1) ? S_PUSH : S_MULP;
            end
            // Restoring division, one quotient bit per cycle
            S_DIV: begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = 32'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == '0) begin
                    state_next = S_DIVF;
                end
            end
            S_DIVF: begin
                fm         = from_mag(neg_reg, 64'(quo_reg));
                flag_en    = fm.sat;
                flag_code  = ST_SAT;
                res_next   = fm.value;
                state_next = S_PUSH;
            end
            // Push the result, drop it on a full stack
            S_PUSH: begin
                if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                    flag_en   = 1'b1;
                    flag_code = ST_OVER;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_IDLE;
            end
            // Read the top for the result
            S_ENDR: begin
                fmem_next = (count_reg != '0);
                if (count_reg == '0) begin
                    flag_en   = 1'b1;
                    flag_code = ST_UNDER;
                end else begin
                    rd_en = 1'b1;
                end
                state_next = S_OUT;
            end
            // Emit the result and clear the expression state
            S_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = fmem_reg ? rd_data_reg : 32'd0;
                    m_status_next = sticky_reg;
                    count_next    = '0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_OUT && out_free) begin
            sticky_next = ST_OK;
        end else if (flag_en && sticky_reg == ST_OK) begin
            sticky_next = flag_code;
        end else begin
            sticky_next = sticky_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            sticky_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sticky_reg  <= sticky_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        e_reg        <= e_next;
        b_reg        <= b_next;
        res_reg      <= res_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        mcnt_reg     <= mcnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        dcnt_reg     <= dcnt_next;
        fmem_reg     <= fmem_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    // Operand stack memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[count_reg[ADDR_W-1:0]] <= res_reg;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    `PEE_CHECK(a_count_bound, count_reg <= CNT_W'(STACK_DEPTH))
    `PEE_CHECK(a_write_in_range, wr_en |-> count_reg < CNT_W'(STACK_DEPTH))
    `PEE_CHECK(a_end_clears, (state_reg == S_OUT && out_free) |=> (count_reg == '0 && sticky_reg == ST_OK && m_valid_reg))

endmodule

### rtl/postfix_expression_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix evaluator on a 32-entry Q16.16 operand stack.
//
//   channel  direction  ports
//   s_       in         s_valid s_ready s_character[7:0] s_end_marker
//   m_       out        m_valid m_ready m_value[31:0] m_status[2:0]
//
// Back-end work per transaction: a space is dropped at the front, divide runs
// one quotient bit per cycle (a zero divisor skips the loop), and power repeats
// the multiply up to 63 times.
// A two-entry command queue lets the front keep accepting, until it fills, while the back works.
// aresetn is synchronous and clears the stack count, status and queue.
// An end transaction waits in the back end while a previous result is not taken.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core
    import pee_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_end_marker,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_value,
    output logic [2:0]  m_status
);

    logic op_valid;
    logic op_ready;
    op_t  op;
    logic [31:0] value_w;

    pee_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_character  (s_character),
        .s_end_marker (s_end_marker),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op_out       (op)
    );

    pee_exec u_exec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op_in    (op),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (value_w),
        .m_status (m_status)
    );

    assign m_value = $signed(value_w);

endmodule

### tb/tb_postfix_expression_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator_core
// Drives postfix character streams into the evaluator and compares each
// emitted value and status against an in-bench fixed-point stack model.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator_core;
    import pee_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_character = 8'd0;
    logic        s_end_marker = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_value;
    logic [2:0]  m_status;

    // model state
    logic signed [31:0] mdl_stack [STACK_DEPTH];
    int unsigned        mdl_count;
    logic [2:0]         mdl_err;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
    } result_t;
    result_t expected_results[$];

    int errors = 0;
    int sent_chars = 0;
    int seen_results = 0;
    int idle_cycles = 0;
    int unsigned rdy_wait = 0;
    bit timed_out = 1'b0;

    postfix_expression_evaluator_core DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- fixed-point stack model ----------------
    function automatic void raise(input logic [2:0] code);
        if (mdl_err == ST_OK) mdl_err = code;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic signed [31:0] rebuild(input bit neg, input logic [63:0] mag);
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                raise(ST_SAT);
                return 32'sh8000_0000;
            end
            return -mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF) begin
            raise(ST_SAT);
            return 32'sh7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    function automatic logic signed [31:0] clamp64(input logic signed [63:0] s);
        if (s > 64'sh7FFF_FFFF) begin
            raise(ST_SAT);
            return 32'sh7FFF_FFFF;
        end
        if (s < -64'sh8000_0000) begin
            raise(ST_SAT);
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mult(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [63:0] m;
        m = (abs64(a) * abs64(b)) >> FRAC_BITS;
        return rebuild(a[31] != b[31], m);
    endfunction

    function automatic logic signed [31:0] fx_quot(input logic signed [31:0] n,
                                                   input logic signed [31:0] d);
        logic [63:0] m;
        if (d == 0) begin
            raise(ST_DIVZ);
            return 0;
        end
        m = (abs64(n) << FRAC_BITS) / abs64(d);
        return rebuild(n[31] != d[31], m);
    endfunction

    function automatic logic signed [31:0] fx_power(input logic signed [31:0] b,
                                                    input logic signed [31:0] e);
        logic signed [63:0] one, x, n, e64;
        logic signed [31:0] r;
        one = 64'sd1 <<< FRAC_BITS;
        e64 = e;
        x = e64 - one;
        r = b;
        if (e == 0) return one[31:0];
        if (x <= 0) return b;
        n = (x + one - 1) >>> FRAC_BITS;
        if (n > POW_CAP) n = POW_CAP;
        for (int i = 0; i < n; i++) r = fx_mult(r, b);
        return r;
    endfunction

    function automatic void model_push(input logic signed [31:0] v);
        if (mdl_count >= STACK_DEPTH) begin
            raise(ST_OVER);
            return;
        end
        mdl_stack[mdl_count] = v;
        mdl_count++;
    endfunction

    function automatic logic signed [31:0] model_pop();
        if (mdl_count == 0) begin
            raise(ST_UNDER);
            return 0;
        end
        mdl_count--;
        return mdl_stack[mdl_count];
    endfunction

    function automatic void evaluate_char(input logic [7:0] ch, input logic endm);
        logic signed [31:0] e, b, v;
        result_t r;
        if (endm) begin
            v = model_pop();
            r.value = v;
            r.status = mdl_err;
            expected_results.push_back(r);
            mdl_count = 0;
            mdl_err = ST_OK;
            return;
        end
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            model_push({12'd0, ch[3:0] - 4'd0, 16'd0} & 32'h000F_0000 |
                       (32'(ch - CH_ZERO) << FRAC_BITS));
            return;
        end
        if (ch == CH_SPACE) return;
        e = model_pop();
        b = model_pop();
        case (ch)
            CH_PLUS:  model_push(clamp64(64'(b) + 64'(e)));
            CH_MINUS: model_push(clamp64(64'(b) - 64'(e)));
            CH_STAR:  model_push(fx_mult(b, e));
            CH_SLASH: model_push(fx_quot(b, e));
            CH_CARET: model_push(fx_power(b, e));
            default: ;
        endcase
    endfunction

    // ---------------- stimulus ----------------
    // valid stays high across back-to-back transactions; drop it only for a gap
    task automatic send_char(input logic [7:0] ch, input logic endm);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_character <= ch;
        s_end_marker <= endm;
        do @(posedge aclk); while (!s_ready);
        evaluate_char(ch, endm);
        sent_chars++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_basic_ops();
        send_string("34+");
        send_string("9 3-");
        send_string("23*");
        send_string("72/");
        send_string("23^");
        send_string("20^");
        send_string("31^");
        send_string("05-");
        send_string("34?");
    endtask

    task automatic test_error_cases();
        send_string("");          // end on empty stack
        send_string("+");         // underflow
        send_string("50/");       // divide by zero
        send_string("99^9^");     // saturation
        send_string("09-99^9^*"); // negative saturation
        send_string("123456789012345678901234567890123"); // overflow
        send_string("1+0/");      // first error kept
    endtask

    task automatic test_random_exprs();
        string ops;
        logic [7:0] ch;
        int depth, len;
        ops = "+-*/^";
        while (sent_chars < 500) begin
            if ($urandom_range(0, 9) < 8) begin
                // well-formed expression with random digits and operators
                depth = 0;
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if (depth < 2 || ($urandom_range(0, 1) && depth < 30)) begin
                        send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
                        depth++;
                    end else begin
                        send_char(ops[$urandom_range(0, 4)], 1'b0);
                        depth--;
                    end
                    if ($urandom_range(0, 7) == 0) send_char(CH_SPACE, 1'b0);
                end
            end else begin
                // noise characters
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    ch = 8'($urandom_range(0, 255));
                    send_char(ch, 1'b0);
                end
            end
            send_char(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // ---------------- result side ----------------
    // hold ready low for a drawn number of cycles before each result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rdy_wait <= $urandom_range(0, 15);
        end else if (m_valid && m_ready) begin
            m_ready  <= 1'b0;
            rdy_wait <= $urandom_range(0, 15);
        end else if (rdy_wait != 0) begin
            m_ready <= 1'b0;
            if (m_valid) rdy_wait <= rdy_wait - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // check each result transaction
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            seen_results++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result value=%h status=%0d",
                         $time, m_value, m_status);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_value !== exp_r.value) begin
                    $display("%0t: value expected %h actual %h", $time, exp_r.value, m_value);
                    errors++;
                end
                if (m_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, m_status);
                    errors++;
                end
            end
        end
    end

    // watchdog: count cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        mdl_count = 0;
        mdl_err = ST_OK;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_ops();
        test_error_cases();
        test_random_exprs();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d characters, checked %0d expression results.",
                 sent_chars, seen_results);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
